>>> hdl/mpsd_pkg.sv
package mpsd_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int STACK_DEPTH = 4096;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int CNT_W   = 7;
    localparam int CELL_W  = ROW_W + COL_W;
    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int DIR_W   = 4;
    localparam int SP_W    = $clog2(STACK_DEPTH) + 1;
    localparam int SADDR_W = $clog2(STACK_DEPTH);
    localparam int FRAME_W = ROW_W + COL_W + DIR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [DIR_W-1:0] DIR_END = DIR_W'(8);

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 3'd0,
        CFG_COL_COUNT = 3'd1,
        CFG_START_ROW = 3'd2,
        CFG_START_COL = 3'd3,
        CFG_GOAL_ROW  = 3'd4,
        CFG_GOAL_COL  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CODE_OPEN = 2'd0,
        CODE_WALL = 2'd1,
        CODE_PATH = 2'd2
    } t_code;

    typedef struct packed {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [DIR_W-1:0] d;
    } t_frame;

    function automatic logic signed [1:0] step_dr(input logic [DIR_W-1:0] d);
        logic signed [1:0] v;
        case (d)
            4'd0, 4'd1, 4'd7: v = -2'sd1;
            4'd3, 4'd4, 4'd5: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] step_dc(input logic [DIR_W-1:0] d);
        logic signed [1:0] v;
        case (d)
            4'd1, 4'd2, 4'd3: v = 2'sd1;
            4'd5, 4'd6, 4'd7: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/mpsd_ram.sv
module mpsd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/maze_path_search_dfs.sv
// Cell write, unused op: one word per cycle when idle, result strobe in the next cycle.
// Cell read: result strobe next cycle (registered memory read); one per cycle if idle.
// Search: clears the visited and path stores, loads the start, then probes each neighbor
// direction, in-grid and off-grid, pops the stack when a cell is exhausted, marks every
// stack entry on the path and closes by marking the current, start and goal cells.
// Reset runs a clearing pass with busy high; the receiver cannot stall.
module maze_path_search_dfs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_op,
    input  logic [mpsd_pkg::ROW_W-1:0]     i_row,
    input  logic [mpsd_pkg::COL_W-1:0]     i_col,
    input  logic                           i_wall,
    input  logic                           i_cfg_we,
    input  logic [mpsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mpsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [1:0]                     o_cell_code
);
    import mpsd_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CLR   = 12'b0000_0000_0010,
        S_INIT  = 12'b0000_0000_0100,
        S_PROBE = 12'b0000_0000_1000,
        S_TEST  = 12'b0000_0001_0000,
        S_POPL  = 12'b0000_0010_0000,
        S_MRD   = 12'b0000_0100_0000,
        S_MWR   = 12'b0000_1000_0000,
        S_MCUR  = 12'b0001_0000_0000,
        S_MST   = 12'b0010_0000_0000,
        S_MGL   = 12'b0100_0000_0000,
        S_POP   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    logic   r_boot;
    logic [CNT_W-1:0] r_row_count, r_col_count;
    logic [ROW_W-1:0] r_start_row, r_goal_row, r_cur_r, r_nr;
    logic [COL_W-1:0] r_start_col, r_goal_col, r_cur_c, r_nc;
    logic [DIR_W-1:0] r_cur_d;
    logic [SP_W-1:0]  r_sp, r_idx;
    logic [CELL_W-1:0] r_clr;
    logic r_found, r_out_vld, r_rd_pend, r_rd_in;

    logic [CNT_W-1:0] rows_used, cols_used;
    logic accept;
    logic signed [ROW_W+1:0] nr_s;
    logic signed [COL_W+1:0] nc_s;
    logic n_in_grid, start_in, rd_in;
    logic [SP_W-1:0] sp_dec;

    logic wall_we, wall_q, wall_wd;
    logic [CELL_W-1:0] wall_wa, wall_ra;
    logic vis_we, vis_q, vis_wd;
    logic [CELL_W-1:0] vis_wa;
    logic path_we, path_q, path_wd;
    logic [CELL_W-1:0] path_wa, path_ra;
    logic stk_we;
    logic [SADDR_W-1:0] stk_wa, stk_ra;
    t_frame stk_wd, stk_q;
    logic open_n;

    assign rows_used = (r_row_count > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : r_row_count;
    assign cols_used = (r_col_count > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : r_col_count;
    assign o_busy    = (r_state != S_IDLE);
    assign accept    = i_start && !o_busy;

    assign nr_s = $signed({2'b00, r_cur_r}) + (ROW_W+2)'(step_dr(r_cur_d));
    assign nc_s = $signed({2'b00, r_cur_c}) + (COL_W+2)'(step_dc(r_cur_d));
    assign n_in_grid = !nr_s[ROW_W+1] && !nc_s[COL_W+1]
                    && (nr_s[ROW_W:0] < (ROW_W+1)'(rows_used))
                    && (nc_s[COL_W:0] < (COL_W+1)'(cols_used));
    assign start_in = ({1'b0, r_start_row} < rows_used) && ({1'b0, r_start_col} < cols_used);
    assign rd_in    = ({1'b0, i_row} < rows_used) && ({1'b0, i_col} < cols_used);
    assign sp_dec   = r_sp - SP_W'(1);
    assign open_n   = !wall_q;

    always_comb begin
        wall_we = accept && (t_op'(i_op) == OP_WRITE)
               && ({1'b0, i_row} < (ROW_W+1)'(MAX_ROWS))
               && ({1'b0, i_col} < (COL_W+1)'(MAX_COLS));
        wall_wa = {i_row, i_col};
        wall_wd = i_wall;
        wall_ra = (r_state == S_PROBE) ? {nr_s[ROW_W-1:0], nc_s[COL_W-1:0]} : {i_row, i_col};

        vis_we = 1'b0;
        vis_wa = r_clr;
        vis_wd = 1'b0;
        path_we = 1'b0;
        path_wa = r_clr;
        path_wd = 1'b0;
        path_ra = {i_row, i_col};
        stk_we  = 1'b0;
        stk_wa  = r_sp[SADDR_W-1:0];
        stk_wd  = '{r: r_cur_r, c: r_cur_c, d: r_cur_d + DIR_W'(1)};
        stk_ra  = (r_state == S_PROBE) ? sp_dec[SADDR_W-1:0] :
                  (r_state == S_POP)   ? r_sp[SADDR_W-1:0]   : r_idx[SADDR_W-1:0];

        unique case (r_state)
            S_CLR: begin
                vis_we  = 1'b1;
                path_we = 1'b1;
            end
            S_INIT: begin
                vis_we = start_in;
                vis_wa = {r_start_row, r_start_col};
                vis_wd = 1'b1;
            end
            S_TEST: begin
                vis_we = open_n && !({r_nr, r_nc} == {r_goal_row, r_goal_col}) && !vis_q;
                vis_wa = {r_nr, r_nc};
                vis_wd = 1'b1;
                stk_we = vis_we && (r_sp != SP_W'(STACK_DEPTH));
            end
            S_MWR: begin
                path_we = 1'b1;
                path_wa = {stk_q.r, stk_q.c};
                path_wd = 1'b1;
            end
            S_MCUR: begin
                path_we = 1'b1;
                path_wa = {r_cur_r, r_cur_c};
                path_wd = 1'b1;
            end
            S_MST: begin
                path_we = 1'b1;
                path_wa = {r_start_row, r_start_col};
                path_wd = 1'b1;
            end
            S_MGL: begin
                path_we = 1'b1;
                path_wa = {r_goal_row, r_goal_col};
                path_wd = 1'b1;
            end
            default: begin
            end
        endcase
    end

    mpsd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
        .i_clk(i_clk), .i_we(wall_we), .i_waddr(wall_wa), .i_wdata(wall_wd),
        .i_raddr(wall_ra), .o_rdata(wall_q)
    );
    mpsd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_wa), .i_wdata(vis_wd),
        .i_raddr({nr_s[ROW_W-1:0], nc_s[COL_W-1:0]}), .o_rdata(vis_q)
    );
    mpsd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_wa), .i_wdata(path_wd),
        .i_raddr(path_ra), .o_rdata(path_q)
    );
    mpsd_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_W'(1);
            r_col_count <= CNT_W'(1);
            r_start_row <= '0;
            r_start_col <= '0;
            r_goal_row  <= '0;
            r_goal_col  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_COL_COUNT: r_col_count <= i_cfg_data;
                CFG_START_ROW: r_start_row <= i_cfg_data[ROW_W-1:0];
                CFG_START_COL: r_start_col <= i_cfg_data[COL_W-1:0];
                CFG_GOAL_ROW:  r_goal_row  <= i_cfg_data[ROW_W-1:0];
                CFG_GOAL_COL:  r_goal_col  <= i_cfg_data[COL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_boot    <= 1'b1;
            r_clr     <= '0;
            r_sp      <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_in   <= 1'b0;
            r_cur_d   <= '0;
        end else begin
            r_out_vld <= 1'b0;
            r_rd_pend <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (t_op'(i_op) == OP_SEARCH) begin
                            r_found <= 1'b0;
                            r_clr   <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_out_vld <= 1'b1;
                            r_rd_pend <= (t_op'(i_op) == OP_READ);
                            r_rd_in   <= rd_in;
                        end
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + CELL_W'(1);
                    if (r_clr == '1) begin
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_INIT;
                    end
                end
                S_INIT: begin
                    r_sp    <= '0;
                    r_cur_r <= r_start_row;
                    r_cur_c <= r_start_col;
                    r_cur_d <= '0;
                    if (start_in) begin
                        r_state <= S_PROBE;
                    end else begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_PROBE: begin
                    r_nr <= nr_s[ROW_W-1:0];
                    r_nc <= nc_s[COL_W-1:0];
                    if (r_cur_d == DIR_END) begin
                        if (r_sp == '0) begin
                            r_out_vld <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_sp    <= sp_dec;
                            r_state <= S_POP;
                        end
                    end else if (n_in_grid) begin
                        r_state <= S_TEST;
                    end else begin
                        r_cur_d <= r_cur_d + DIR_W'(1);
                    end
                end
                S_POP: begin
                    r_state <= S_POPL;
                end
                S_POPL: begin
                    r_cur_r <= stk_q.r;
                    r_cur_c <= stk_q.c;
                    r_cur_d <= stk_q.d;
                    r_state <= S_PROBE;
                end
                S_TEST: begin
                    if (open_n && ({r_nr, r_nc} == {r_goal_row, r_goal_col})) begin
                        r_idx   <= '0;
                        r_state <= S_MRD;
                    end else if (open_n && !vis_q) begin
                        if (r_sp == SP_W'(STACK_DEPTH)) begin
                            r_sp      <= '0;
                            r_out_vld <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_sp    <= r_sp + SP_W'(1);
                            r_cur_r <= r_nr;
                            r_cur_c <= r_nc;
                            r_cur_d <= '0;
                            r_state <= S_PROBE;
                        end
                    end else begin
                        r_cur_d <= r_cur_d + DIR_W'(1);
                        r_state <= S_PROBE;
                    end
                end
                S_MRD: begin
                    r_state <= (r_idx == r_sp) ? S_MCUR : S_MWR;
                end
                S_MWR: begin
                    r_idx   <= r_idx + SP_W'(1);
                    r_state <= S_MRD;
                end
                S_MCUR: begin
                    r_state <= S_MST;
                end
                S_MST: begin
                    r_state <= S_MGL;
                end
                S_MGL: begin
                    r_found   <= 1'b1;
                    r_out_vld <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cell_code = CODE_OPEN;
        if (r_rd_pend) begin
            if (!r_rd_in) begin
                o_cell_code = CODE_WALL;
            end else if (path_q) begin
                o_cell_code = CODE_PATH;
            end else if (wall_q) begin
                o_cell_code = CODE_WALL;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_found = r_found;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_boot_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boot |-> !o_valid && o_busy)
        else $error("result during reset clearing pass");

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_op == OP_SEARCH) |=> (r_state == S_CLR) && !o_found)
        else $error("search did not enter clearing pass");

    a_test_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> $past(r_state) == S_PROBE)
        else $error("neighbor test without probe");

    a_found_at_mark_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MGL) |=> o_valid && o_found && !o_busy)
        else $error("path marking ended without found result");
endmodule

>>> dv/maze_path_search_dfs_tb.sv
module maze_path_search_dfs_tb;
    import mpsd_pkg::*;

    typedef struct {
        logic       found;
        logic [1:0] code;
    } t_word;

    typedef struct {
        bit         is_cfg;
        logic [2:0] idx;
        logic [6:0] data;
        logic [1:0] op;
        logic [5:0] row;
        logic [5:0] col;
        logic       wall;
        bit         typed;
        logic       found;
        logic [1:0] code;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic [1:0]            i_op = '0;
    logic [ROW_W-1:0]      i_row = '0;
    logic [COL_W-1:0]      i_col = '0;
    logic                  i_wall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic                  o_found;
    logic [1:0]            o_cell_code;

    maze_path_search_dfs u_dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // maze state
    int unsigned rows_m = 1, cols_m = 1, srow_m = 0, scol_m = 0, grow_m = 0, gcol_m = 0;
    bit          wall_m [CELLS];
    bit          seen_m [CELLS];
    bit          path_m [CELLS];
    bit          written_m [CELLS];
    int          stk_r [STACK_DEPTH];
    int          stk_c [STACK_DEPTH];
    int          stk_d [STACK_DEPTH];
    bit          found_m = 1'b0;

    t_word       pending_q [$];
    int          errors = 0;
    int          items = 0;
    bit          quiet = 1'b0;

    function automatic int rows_used();
        return rows_m < MAX_ROWS ? rows_m : MAX_ROWS;
    endfunction

    function automatic int cols_used();
        return cols_m < MAX_COLS ? cols_m : MAX_COLS;
    endfunction

    function automatic bit on_grid(int r, int c);
        return r >= 0 && c >= 0 && r < rows_used() && c < cols_used();
    endfunction

    function automatic bit is_free(int r, int c);
        return on_grid(r, c) && !wall_m[r * MAX_COLS + c];
    endfunction

    function automatic void dfs_search();
        int  r, c, d, nr, nc, sp;
        bit  hit;
        bit  free;
        hit = 1'b0;
        for (int k = 0; k < CELLS; k++) begin
            seen_m[k] = 1'b0;
            path_m[k] = 1'b0;
        end
        found_m = 1'b0;
        if (!on_grid(srow_m, scol_m)) return;
        seen_m[srow_m * MAX_COLS + scol_m] = 1'b1;
        stk_r[0] = srow_m;
        stk_c[0] = scol_m;
        stk_d[0] = 0;
        sp = 1;
        r = srow_m;
        c = scol_m;
        while (sp > 0 && !hit) begin
            sp--;
            r = stk_r[sp];
            c = stk_c[sp];
            d = stk_d[sp];
            while (d < 8 && !hit) begin
                nr = r + ((d == 0 || d == 1 || d == 7) ? -1 : (d >= 3 && d <= 5) ? 1 : 0);
                nc = c + ((d >= 1 && d <= 3) ? 1 : (d >= 5) ? -1 : 0);
                free = is_free(nr, nc);
                if (free && nr == grow_m && nc == gcol_m) begin
                    hit = 1'b1;
                end else if (free && !seen_m[nr * MAX_COLS + nc]) begin
                    seen_m[nr * MAX_COLS + nc] = 1'b1;
                    if (sp >= STACK_DEPTH) return;
                    stk_r[sp] = r;
                    stk_c[sp] = c;
                    stk_d[sp] = d + 1;
                    sp++;
                    r = nr;
                    c = nc;
                    d = 0;
                end else begin
                    d++;
                end
            end
        end
        if (!hit) return;
        found_m = 1'b1;
        for (int k = 0; k < sp; k++) path_m[stk_r[k] * MAX_COLS + stk_c[k]] = 1'b1;
        path_m[r * MAX_COLS + c] = 1'b1;
        path_m[srow_m * MAX_COLS + scol_m] = 1'b1;
        path_m[grow_m * MAX_COLS + gcol_m] = 1'b1;
    endfunction

    function automatic t_word maze_step(logic [1:0] op, int r, int c, logic w);
        t_word res;
        res.code = CODE_OPEN;
        case (op)
            OP_WRITE: begin
                wall_m[r * MAX_COLS + c] = w;
                written_m[r * MAX_COLS + c] = 1'b1;
            end
            OP_SEARCH: dfs_search();
            OP_READ: begin
                if (!on_grid(r, c)) res.code = CODE_WALL;
                else if (path_m[r * MAX_COLS + c]) res.code = CODE_PATH;
                else if (wall_m[r * MAX_COLS + c]) res.code = CODE_WALL;
            end
            default: ;
        endcase
        res.found = found_m;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: found %0d code %0d",
                                           o_found, o_cell_code);
            end else begin
                want = pending_q.pop_front();
                if (o_found !== want.found || o_cell_code !== want.code) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp found %0d code %0d, got found %0d code %0d",
                                 want.found, want.code, o_found, o_cell_code);
                end
            end
        end
    end

    task automatic drain();
        while (pending_q.size() != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [6:0] data);
        drain();
        i_start = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_ROW_COUNT: rows_m = data;
            CFG_COL_COUNT: cols_m = data;
            CFG_START_ROW: srow_m = data[5:0];
            CFG_START_COL: scol_m = data[5:0];
            CFG_GOAL_ROW:  grow_m = data[5:0];
            CFG_GOAL_COL:  gcol_m = data[5:0];
            default: ;
        endcase
    endtask

    task automatic send(logic [1:0] op, logic [5:0] r, logic [5:0] c, logic w,
                        bit typed = 0, logic f = 0, logic [1:0] code = 0);
        t_word res;
        if (!quiet && $urandom_range(99) < 28) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_op = op;
        i_row = r;
        i_col = c;
        i_wall = w;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        res = maze_step(op, r, c, w);
        if (typed) begin
            res.found = f;
            res.code = code;
        end
        pending_q.push_back(res);
        items++;
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic set_maze(int rc, int cc, int sr, int sc, int gr, int gc);
        cfg_write(CFG_ROW_COUNT, 7'(rc));
        cfg_write(CFG_COL_COUNT, 7'(cc));
        cfg_write(CFG_START_ROW, 7'(sr));
        cfg_write(CFG_START_COL, 7'(sc));
        cfg_write(CFG_GOAL_ROW, 7'(gr));
        cfg_write(CFG_GOAL_COL, 7'(gc));
    endtask

    t_row directed [] = '{
        '{0, 0, 0, OP_WRITE, 0, 0, 0, 1, 0, CODE_OPEN},
        '{0, 0, 0, OP_READ, 0, 0, 0, 1, 0, CODE_OPEN},
        '{0, 0, 0, OP_READ, 63, 63, 1, 1, 0, CODE_WALL},
        '{0, 0, 0, OP_SEARCH, 0, 0, 0, 1, 0, CODE_OPEN},
        '{0, 0, 0, 2'd3, 63, 63, 1, 1, 0, CODE_OPEN},
        '{0, 0, 0, OP_WRITE, 63, 63, 1, 1, 0, CODE_OPEN},
        '{0, 0, 0, OP_READ, 63, 63, 0, 1, 0, CODE_WALL},
        '{1, CFG_COL_COUNT, 2, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, OP_WRITE, 0, 1, 0, 1, 0, CODE_OPEN},
        '{0, 0, 0, OP_SEARCH, 0, 0, 0, 1, 1, CODE_OPEN},
        '{0, 0, 0, OP_READ, 0, 0, 0, 1, 1, CODE_PATH},
        '{0, 0, 0, OP_READ, 0, 1, 0, 1, 1, CODE_PATH},
        '{0, 0, 0, OP_WRITE, 0, 0, 1, 1, 1, CODE_OPEN},
        '{0, 0, 0, OP_SEARCH, 0, 0, 0, 1, 0, CODE_OPEN},
        '{0, 0, 0, OP_READ, 0, 0, 0, 1, 0, CODE_WALL},
        '{1, CFG_ROW_COUNT, 1, 0, 0, 0, 0, 0, 0, 0},
        '{1, CFG_START_ROW, 63, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SEARCH, 0, 0, 0, 1, 0, CODE_OPEN},
        '{1, CFG_ROW_COUNT, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, CFG_START_ROW, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, OP_READ, 0, 0, 0, 1, 0, CODE_WALL},
        '{0, 0, 0, OP_SEARCH, 0, 0, 0, 1, 0, CODE_OPEN},
        '{0, 0, 0, 2'd3, 0, 0, 0, 1, 0, CODE_OPEN}
    };

    initial begin
        int rc, cc, sr, sc, gr, gc, n, pick, r, c, phase;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            if (directed[k].is_cfg)
                cfg_write(t_cfg_idx'(directed[k].idx), directed[k].data);
            else
                send(directed[k].op, directed[k].row, directed[k].col, directed[k].wall,
                     directed[k].typed, directed[k].found, directed[k].code);
        end

        phase = 0;
        while (items < 1550) begin
            case (phase)
                2: begin rc = 64; cc = 8; end
                5: begin rc = 64; cc = 1; end
                8: begin rc = 1; cc = 64; end
                default: begin rc = $urandom_range(1, 8); cc = $urandom_range(1, 8); end
            endcase
            if ($urandom_range(9) == 0) begin
                sr = $urandom_range(63);
                sc = $urandom_range(63);
            end else begin
                sr = $urandom_range(rc - 1);
                sc = $urandom_range(cc - 1);
            end
            gr = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(rc - 1);
            gc = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(cc - 1);
            set_maze(rc, cc, sr, sc, gr, gc);
            quiet = (phase % 5 == 3);
            for (int y = 0; y < rc; y++)
                for (int x = 0; x < cc; x++)
                    if (!written_m[y * MAX_COLS + x] || $urandom_range(3) == 0)
                        send(OP_WRITE, 6'(y), 6'(x), $urandom_range(99) < 30);
            n = $urandom_range(20, 60);
            repeat (n) begin
                pick = $urandom_range(99);
                r = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(rc - 1);
                c = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(cc - 1);
                if (pick < 40) begin
                    send(OP_WRITE, 6'(r), 6'(c), 1'($urandom_range(1)));
                end else if (pick < 75) begin
                    if (on_grid(r, c) || written_m[r * MAX_COLS + c] || 1)
                        send(OP_READ, 6'(r), 6'(c), 1'($urandom_range(1)));
                end else if (pick < 95) begin
                    if (rc * cc <= 64 || $urandom_range(3) == 0)
                        send(OP_SEARCH, 6'(r), 6'(c), 1'($urandom_range(1)));
                end else begin
                    send(2'd3, 6'(r), 6'(c), 1'($urandom_range(1)));
                end
            end
            phase++;
        end

        i_start = 1'b0;
        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/mpsd_pkg.sv
hdl/mpsd_ram.sv
hdl/maze_path_search_dfs.sv
dv/maze_path_search_dfs_tb.sv
